/* sv/rfb_pkg.sv */
// shared types and constants for the ring fifo burst unit
`timescale 1ns / 1ps

package rfb_pkg;

   localparam int COUNT_W            = 5;
   localparam int CMD_W              = 2;
   localparam int STATUS_W           = 2;
   localparam int MAX_BURST          = 16;
   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_PUT   = 2'd1,
      CMD_GET   = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // decoded command as it travels from front to back
   typedef struct packed {
      cmd_type              cmd;
      logic [COUNT_W-1:0]   cnt;
   } op_type;

   localparam int OP_W = $bits(op_type);

endpackage

/* sv/rfb_channels.sv */
// request and response channel interfaces of the ring fifo burst unit
`timescale 1ns / 1ps

interface rfb_req_if
   import rfb_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      command;
   logic [COUNT_W-1:0]    count;
   logic [DATA_WIDTH-1:0] data_in;

   modport source (output valid, command, count, data_in, input ready);
   modport sink   (input valid, command, count, data_in, output ready);
endinterface

interface rfb_rsp_if
   import rfb_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int DEPTH      = DEPTH_DEFAULT
);
   localparam int OCC_W = $clog2(DEPTH + 1);

   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [DATA_WIDTH-1:0] data_out;
   logic                  last;
   logic [OCC_W-1:0]      occupancy;

   modport source (output valid, status, data_out, last, occupancy, input ready);
   modport sink   (input valid, status, data_out, last, occupancy, output ready);
endinterface

/* sv/rfb_front.sv */
// front end: takes request words and decodes them for the command queue
`timescale 1ns / 1ps

module rfb_front
   import rfb_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   rfb_req_if.sink               req_bus,
   output logic                  push_valid,
   input  logic                  push_ready,
   output op_type                push_op,
   output logic [DATA_WIDTH-1:0] push_data
);

   always_comb begin
      push_op.cmd = cmd_type'(req_bus.command);
      // a zero count means one
      push_op.cnt = (req_bus.count == '0) ? COUNT_W'(1) : req_bus.count;
   end

   assign push_data     = req_bus.data_in;
   assign push_valid    = req_bus.valid;
   assign req_bus.ready = push_ready;

endmodule

/* sv/rfb_queue.sv */
// two-entry command queue between front end and back end
`timescale 1ns / 1ps

module rfb_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       used_ff, used_in;
   logic             push_go, pop_go;

   assign push_ready = (used_ff != 2'd2);
   assign pop_valid  = (used_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push_go    = push_valid & push_ready;
   assign pop_go     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = push_go ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_go  ? ~rd_ptr_ff : rd_ptr_ff;
      used_in   = used_ff + {1'b0, push_go} - {1'b0, pop_go};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         used_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_go) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/rfb_back.sv */
// back end: ring storage, occupancy, put runs and get bursts
`timescale 1ns / 1ps

module rfb_back
   import rfb_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  op_valid,
   output logic                  op_ready,
   input  op_type                op,
   input  logic [DATA_WIDTH-1:0] op_data,
   rfb_rsp_if.source             rsp_bus
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((OCC_W > COUNT_W) ? OCC_W : COUNT_W) + 1;

   typedef enum logic {
      S_IDLE,
      S_BURST
   } state_type;

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [OCC_W-1:0]      fill_ff, fill_in;
   logic [COUNT_W-1:0]    put_rem_ff, put_rem_in;
   logic                  put_refused_ff, put_refused_in;
   logic [COUNT_W-1:0]    burst_rem_ff, burst_rem_in;

   logic                  out_valid_ff, out_valid_in;
   status_type            out_status_ff, out_status_in;
   logic                  out_last_ff, out_last_in;
   logic [OCC_W-1:0]      out_occ_ff, out_occ_in;
   logic [DATA_WIDTH-1:0] out_data_ff;

   logic                  advance;
   logic                  do_write;
   logic                  do_read;
   logic [COUNT_W-1:0]    run_len;
   logic                  run_refused;
   logic                  get_short;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
      next_idx = (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
   endfunction

   // output slot is free or being emptied this cycle
   assign advance  = ~out_valid_ff | rsp_bus.ready;
   assign op_ready = (state_ff == S_IDLE) & advance;

   always_comb begin
      state_in       = state_ff;
      wr_idx_in      = wr_idx_ff;
      rd_idx_in      = rd_idx_ff;
      fill_in        = fill_ff;
      put_rem_in     = put_rem_ff;
      put_refused_in = put_refused_ff;
      burst_rem_in   = burst_rem_ff;
      out_valid_in   = out_valid_ff & ~rsp_bus.ready;
      out_status_in  = out_status_ff;
      out_last_in    = out_last_ff;
      out_occ_in     = out_occ_ff;
      do_write       = 1'b0;
      do_read        = 1'b0;

      // first item of a run takes the length and does the space check
      run_len     = (put_rem_ff == '0) ? op.cnt : put_rem_ff;
      run_refused = (put_rem_ff == '0)
                  ? ((CMP_W'(fill_ff) + CMP_W'(op.cnt)) > CMP_W'(DEPTH))
                  : put_refused_ff;
      get_short   = (CMP_W'(op.cnt) > CMP_W'(fill_ff))
                  | (CMP_W'(op.cnt) > CMP_W'(MAX_BURST));

      unique case (state_ff)
         S_IDLE: begin
            if (op_valid && advance) begin
               out_valid_in  = 1'b1;
               out_status_in = ST_OK;
               out_last_in   = 1'b1;
               out_occ_in    = fill_ff;
               unique case (op.cmd)
                  CMD_CLEAR: begin
                     wr_idx_in      = '0;
                     rd_idx_in      = '0;
                     fill_in        = '0;
                     put_rem_in     = '0;
                     put_refused_in = 1'b0;
                     out_occ_in     = '0;
                  end
                  CMD_PUT: begin
                     if (run_refused || fill_ff == OCC_W'(DEPTH)) begin
                        out_status_in = ST_FULL;
                     end else begin
                        do_write   = 1'b1;
                        wr_idx_in  = next_idx(wr_idx_ff);
                        fill_in    = fill_ff + OCC_W'(1);
                        out_occ_in = fill_ff + OCC_W'(1);
                     end
                     put_rem_in     = run_len - COUNT_W'(1);
                     put_refused_in = (run_len == COUNT_W'(1)) ? 1'b0 : run_refused;
                  end
                  CMD_GET: begin
                     if (get_short) begin
                        out_status_in = ST_EMPTY;
                     end else begin
                        do_read     = 1'b1;
                        rd_idx_in   = next_idx(rd_idx_ff);
                        fill_in     = fill_ff - OCC_W'(1);
                        out_occ_in  = fill_ff - OCC_W'(1);
                        out_last_in = (op.cnt == COUNT_W'(1));
                        if (op.cnt != COUNT_W'(1)) begin
                           state_in     = S_BURST;
                           burst_rem_in = op.cnt - COUNT_W'(1);
                        end
                     end
                  end
                  CMD_NOP: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_BURST: begin
            if (advance) begin
               do_read       = 1'b1;
               rd_idx_in     = next_idx(rd_idx_ff);
               fill_in       = fill_ff - OCC_W'(1);
               burst_rem_in  = burst_rem_ff - COUNT_W'(1);
               out_valid_in  = 1'b1;
               out_status_in = ST_OK;
               out_occ_in    = fill_ff - OCC_W'(1);
               out_last_in   = (burst_rem_ff == COUNT_W'(1));
               if (burst_rem_ff == COUNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         wr_idx_ff      <= '0;
         rd_idx_ff      <= '0;
         fill_ff        <= '0;
         put_rem_ff     <= '0;
         put_refused_ff <= 1'b0;
         burst_rem_ff   <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         wr_idx_ff      <= wr_idx_in;
         rd_idx_ff      <= rd_idx_in;
         fill_ff        <= fill_in;
         put_rem_ff     <= put_rem_in;
         put_refused_ff <= put_refused_in;
         burst_rem_ff   <= burst_rem_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // response payload and registered memory read
   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
      out_occ_ff    <= out_occ_in;
      if (do_read) begin
         out_data_ff <= mem[rd_idx_ff];
      end else if (advance) begin
         out_data_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[wr_idx_ff] <= op_data;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.status    = out_status_ff;
   assign rsp_bus.data_out  = out_data_ff;
   assign rsp_bus.last      = out_last_ff;
   assign rsp_bus.occupancy = out_occ_ff;

endmodule

/* sv/ring_fifo_burst_unit.sv */
// top level of the ring fifo burst unit
//
// circular fifo of DEPTH words with burst put and get commands
// req_bus: command (clear, put, get, nop), count, data_in, valid/ready
// rsp_bus: status, data_out, last, occupancy, valid/ready
// a put run is count put words; the first one checks free space for the
// whole run, and a short run is refused word by word with status full
// a get of count words either returns one empty result or count data words
// oldest first, last set on the final one; every result carries occupancy
// a word's first result passes two registers: the accept edge writes the command queue,
// and the response register loads once the back end takes the word from the queue
// throughput: one request word per cycle for clear, put and refused gets while the back
// end is idle and the receiver is ready; an accepted get holds the back end in burst
// state, reading one data word at a time through the single memory read port
// the two-entry queue keeps taking words while the back end is busy
// a stalled receiver freezes the response register and the back end;
// the queue then fills and req ready drops
// reset empties the fifo and queue and ends any put run; storage not cleared
`timescale 1ns / 1ps

module ring_fifo_burst_unit
   import rfb_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   rfb_req_if.sink    req_bus,
   rfb_rsp_if.source  rsp_bus
);

   localparam int QW = OP_W + DATA_WIDTH;

   // front to queue
   logic                  push_valid;
   logic                  push_ready;
   op_type                push_op;
   logic [DATA_WIDTH-1:0] push_data;

   // queue to back
   logic                  pop_valid;
   logic                  pop_ready;
   logic [QW-1:0]         pop_word;
   op_type                pop_op;
   logic [DATA_WIDTH-1:0] pop_data;

   rfb_front #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .push_data  (push_data)
   );

   rfb_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_op, push_data}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_word)
   );

   // split queue word back into decoded command and element
   assign pop_op   = op_type'(pop_word[QW-1:DATA_WIDTH]);
   assign pop_data = pop_word[DATA_WIDTH-1:0];

   rfb_back #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (pop_valid),
      .op_ready (pop_ready),
      .op       (pop_op),
      .op_data  (pop_data),
      .rsp_bus  (rsp_bus)
   );

endmodule
